[design/pid_with_integral_clamp_defines.svh]
// Assertion macros for the PID controller block.
// Used by the port checker; expects aclk and aresetn in the scope of each use.
`ifndef PID_WITH_INTEGRAL_CLAMP_DEFINES_SVH
`define PID_WITH_INTEGRAL_CLAMP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pwic_pkg.sv]
// Shared types and codes for the PID controller block.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`default_nettype none

package pwic_pkg;

    // Datapath operations, one per microcode step.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_INT_ADD   = 4'd2;
    localparam logic [3:0] OP_INT_CLAMP = 4'd3;
    localparam logic [3:0] OP_P_LOAD    = 4'd4;
    localparam logic [3:0] OP_I_ADD     = 4'd5;
    localparam logic [3:0] OP_DIV_INIT  = 4'd6;
    localparam logic [3:0] OP_DIV_STEP  = 4'd7;
    localparam logic [3:0] OP_DIV_FIX   = 4'd8;
    localparam logic [3:0] OP_D_HI      = 4'd9;
    localparam logic [3:0] OP_D_MERGE   = 4'd10;
    localparam logic [3:0] OP_D_ADD     = 4'd11;
    localparam logic [3:0] OP_OUT       = 4'd12;

    // Operand pairs for the shared multiplier.
    localparam logic [2:0] MUL_NONE   = 3'd0;
    localparam logic [2:0] MUL_ERR_DT = 3'd1;
    localparam logic [2:0] MUL_KP_ERR = 3'd2;
    localparam logic [2:0] MUL_KI_INT = 3'd3;
    localparam logic [2:0] MUL_KD_HI  = 3'd4;
    localparam logic [2:0] MUL_KD_LO  = 3'd5;

    // Branch conditions.
    localparam logic [2:0] COND_NEXT     = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_NO_INPUT = 3'd2;
    localparam logic [2:0] COND_CNT_NZ   = 3'd3;
    localparam logic [2:0] COND_OUT_BUSY = 3'd4;

    // Configuration register indexes.
    localparam logic [7:0] CFG_KP_GAIN        = 8'd0;
    localparam logic [7:0] CFG_KI_GAIN        = 8'd1;
    localparam logic [7:0] CFG_KD_GAIN        = 8'd2;
    localparam logic [7:0] CFG_INTEGRAL_LIMIT = 8'd3;

    localparam logic signed [15:0] KP_RESET    = 16'sd256;
    localparam logic [30:0]        LIMIT_RESET = 31'd167772160;

    // Quotient bits of the derivative division: |diff| < 2^16, shifted by 20.
    localparam int DIV_BITS = 36;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] mul;
        logic [2:0] cond;
        logic [3:0] target;
    } pwic_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic cnt_nz;
    } pwic_status_t;

endpackage

`default_nettype wire

[design/pwic_sequencer.sv]
// Microcode sequencer: step counter, program ROM and branch logic.
// Depends on pwic_pkg for the control word layout and codes.
`default_nettype none

module pwic_sequencer (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pwic_pkg::pwic_status_t status,
    output pwic_pkg::pwic_ctrl_t       ctrl
);
    import pwic_pkg::*;

    logic [3:0] pc_reg;
    logic [3:0] pc_next;
    logic       take_jump;

    function automatic pwic_ctrl_t ucode(input logic [3:0] addr);
        pwic_ctrl_t w;
        w = '{op: OP_NOP, mul: MUL_NONE, cond: COND_NEXT, target: 4'd0};
        case (addr)
            4'd0:  w = '{op: OP_LOAD,      mul: MUL_NONE,   cond: COND_NO_INPUT, target: 4'd0};
            4'd1:  w = '{op: OP_NOP,       mul: MUL_ERR_DT, cond: COND_NEXT,     target: 4'd0};
            4'd2:  w = '{op: OP_INT_ADD,   mul: MUL_KP_ERR, cond: COND_NEXT,     target: 4'd0};
            4'd3:  w = '{op: OP_INT_CLAMP, mul: MUL_NONE,   cond: COND_NEXT,     target: 4'd0};
            4'd4:  w = '{op: OP_P_LOAD,    mul: MUL_KI_INT, cond: COND_NEXT,     target: 4'd0};
            4'd5:  w = '{op: OP_I_ADD,     mul: MUL_NONE,   cond: COND_NEXT,     target: 4'd0};
            4'd6:  w = '{op: OP_DIV_INIT,  mul: MUL_NONE,   cond: COND_NEXT,     target: 4'd0};
            4'd7:  w = '{op: OP_DIV_STEP,  mul: MUL_NONE,   cond: COND_CNT_NZ,   target: 4'd7};
            4'd8:  w = '{op: OP_DIV_FIX,   mul: MUL_NONE,   cond: COND_NEXT,     target: 4'd0};
            4'd9:  w = '{op: OP_NOP,       mul: MUL_KD_HI,  cond: COND_NEXT,     target: 4'd0};
            4'd10: w = '{op: OP_D_HI,      mul: MUL_KD_LO,  cond: COND_NEXT,     target: 4'd0};
            4'd11: w = '{op: OP_D_MERGE,   mul: MUL_NONE,   cond: COND_NEXT,     target: 4'd0};
            4'd12: w = '{op: OP_D_ADD,     mul: MUL_NONE,   cond: COND_NEXT,     target: 4'd0};
            4'd13: w = '{op: OP_NOP,       mul: MUL_NONE,   cond: COND_OUT_BUSY, target: 4'd13};
            4'd14: w = '{op: OP_OUT,       mul: MUL_NONE,   cond: COND_ALWAYS,   target: 4'd0};
            default: w = '{op: OP_NOP,     mul: MUL_NONE,   cond: COND_ALWAYS,   target: 4'd0};
        endcase
        return w;
    endfunction

    assign ctrl = ucode(pc_reg);

    always_comb begin
        case (ctrl.cond)
            COND_NEXT:     take_jump = 1'b0;
            COND_ALWAYS:   take_jump = 1'b1;
            COND_NO_INPUT: take_jump = !status.in_valid;
            COND_CNT_NZ:   take_jump = status.cnt_nz;
            COND_OUT_BUSY: take_jump = status.out_busy;
            default:       take_jump = 1'b1;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 4'd0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[design/pwic_datapath.sv]
// Datapath of the PID controller: gain registers, shared multiplier, integral,
// restoring divider for the derivative, accumulator and output register.
// Depends on pwic_pkg; driven by the control word from pwic_sequencer.
`default_nettype none

module pwic_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pwic_pkg::pwic_ctrl_t ctrl,
    input  wire logic                 in_valid,
    input  wire logic signed [15:0]   error_value,
    input  wire logic [15:0]          time_step,
    input  wire logic                 cfg_write,
    input  wire logic [7:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [31:0]               drive_value,
    output logic                      output_saturated,
    output logic                      cnt_nz
);
    import pwic_pkg::*;

    logic signed [15:0] kp_reg;
    logic signed [15:0] ki_reg;
    logic signed [15:0] kd_reg;
    logic [30:0]        limit_reg;

    logic signed [31:0] integral_reg;
    logic signed [15:0] prev_reg;

    logic signed [15:0] err_reg;
    logic [15:0]        dt_reg;
    logic signed [16:0] diff_reg;
    logic signed [32:0] acc_reg;
    logic signed [49:0] prod_reg;
    logic signed [47:0] sum_reg;
    logic [35:0]        qn_reg;
    logic [15:0]        rem_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic signed [36:0] deriv_reg;
    logic signed [52:0] dtmp_reg;

    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_sat_reg;

    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod_next;

    logic signed [32:0] acc_next;
    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;
    logic signed [31:0] integral_next;

    logic signed [16:0] diff_next;
    logic [15:0]        diff_mag;
    logic [16:0]        rem_shift;
    logic               quot_bit;
    logic [15:0]        rem_next;
    logic [36:0]        quot_mag;
    logic signed [36:0] deriv_next;

    logic signed [47:0] p_term;
    logic signed [47:0] i_term;
    logic signed [47:0] d_term;
    logic signed [52:0] prod_ext;
    logic               sat_next;
    logic [31:0]        drive_next;

    // Operand selection for the one shared 33 x 17 multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul)
            MUL_ERR_DT: begin
                mul_a = {{17{err_reg[15]}}, err_reg};
                mul_b = {1'b0, dt_reg};
            end
            MUL_KP_ERR: begin
                mul_a = {{17{err_reg[15]}}, err_reg};
                mul_b = {kp_reg[15], kp_reg};
            end
            MUL_KI_INT: begin
                mul_a = {integral_reg[31], integral_reg};
                mul_b = {ki_reg[15], ki_reg};
            end
            MUL_KD_HI: begin
                mul_a = {{15{deriv_reg[36]}}, deriv_reg[36:19]};
                mul_b = {kd_reg[15], kd_reg};
            end
            MUL_KD_LO: begin
                mul_a = {14'd0, deriv_reg[18:0]};
                mul_b = {kd_reg[15], kd_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Integral: add floor(err * dt / 16), then clamp to the configured bound.
    assign acc_next = {integral_reg[31], integral_reg} + {{4{prod_reg[32]}}, prod_reg[32:4]};
    assign lim_pos  = {2'b00, limit_reg};
    assign lim_neg  = -lim_pos;

    always_comb begin
        if (acc_reg > lim_pos) begin
            integral_next = lim_pos[31:0];
        end else if (acc_reg < lim_neg) begin
            integral_next = lim_neg[31:0];
        end else begin
            integral_next = acc_reg[31:0];
        end
    end

    // Derivative: divide |diff| * 2^20 by dt one quotient bit per step, then
    // restore the sign so the quotient truncates toward zero.
    assign diff_next = {error_value[15], error_value} - {prev_reg[15], prev_reg};
    assign diff_mag  = diff_reg[16] ? 16'(-diff_reg) : diff_reg[15:0];
    assign rem_shift = {rem_reg, qn_reg[35]};
    assign quot_bit  = rem_shift >= {1'b0, dt_reg};
    assign rem_next  = quot_bit ? 16'(rem_shift - {1'b0, dt_reg}) : rem_shift[15:0];
    assign quot_mag  = {1'b0, qn_reg};

    always_comb begin
        if (dt_reg == 16'd0) begin
            deriv_next = '0;
        end else if (neg_reg) begin
            deriv_next = -$signed(quot_mag);
        end else begin
            deriv_next = $signed(quot_mag);
        end
    end

    // Terms of the drive sum, each floored to Q16.16.
    assign p_term   = {{2{prod_reg[49]}}, prod_reg[49:4]};
    assign i_term   = {{14{prod_reg[49]}}, prod_reg[49:16]};
    assign d_term   = {{3{dtmp_reg[52]}}, dtmp_reg[52:8]};
    assign prod_ext = {{3{prod_reg[49]}}, prod_reg};

    assign sat_next   = !((&sum_reg[47:31]) || !(|sum_reg[47:31]));
    assign drive_next = sat_next ? (sum_reg[47] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                 : sum_reg[31:0];

    assign cnt_nz = cnt_reg != 6'd0;

    // Configuration and controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg       <= KP_RESET;
            ki_reg       <= '0;
            kd_reg       <= '0;
            limit_reg    <= LIMIT_RESET;
            integral_reg <= '0;
            prev_reg     <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_KP_GAIN:        kp_reg    <= cfg_data[15:0];
                    CFG_KI_GAIN:        ki_reg    <= cfg_data[15:0];
                    CFG_KD_GAIN:        kd_reg    <= cfg_data[15:0];
                    CFG_INTEGRAL_LIMIT: limit_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (ctrl.op == OP_LOAD && in_valid) begin
                prev_reg <= error_value;
            end
            if (ctrl.op == OP_INT_CLAMP) begin
                integral_reg <= integral_next;
            end
        end
    end

    // Working registers of one request.
    always_ff @(posedge aclk) begin
        if (ctrl.mul != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        case (ctrl.op)
            OP_LOAD: begin
                if (in_valid) begin
                    err_reg  <= error_value;
                    dt_reg   <= time_step;
                    diff_reg <= diff_next;
                end
            end
            OP_INT_ADD:  acc_reg <= acc_next;
            OP_P_LOAD:   sum_reg <= p_term;
            OP_I_ADD:    sum_reg <= sum_reg + i_term;
            OP_DIV_INIT: begin
                qn_reg  <= {diff_mag, 20'd0};
                rem_reg <= '0;
                neg_reg <= diff_reg[16];
                cnt_reg <= 6'(DIV_BITS - 1);
            end
            OP_DIV_STEP: begin
                qn_reg  <= {qn_reg[34:0], quot_bit};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 6'd1;
            end
            OP_DIV_FIX:  deriv_reg <= deriv_next;
            OP_D_HI:     dtmp_reg  <= prod_ext;
            OP_D_MERGE:  dtmp_reg  <= {dtmp_reg[33:0], 19'd0} + prod_ext;
            OP_D_ADD:    sum_reg   <= sum_reg + d_term;
            default: ;
        endcase
    end

    // Output register: holds a finished result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.op == OP_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_OUT) begin
            out_data_reg <= drive_next;
            out_sat_reg  <= sat_next;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign drive_value      = out_data_reg;
    assign output_saturated = out_sat_reg;

endmodule

`default_nettype wire

[design/pid_with_integral_clamp.sv]
// PID controller with a clamped integral, one controller step per request.
// The s_ channel takes one request: s_tdata[15:0] is the signed Q4.12 error,
// s_tdata[31:16] the unsigned Q0.16 time step. The m_ channel returns one
// result per request: m_tdata is the Q16.16 drive, m_tuser is high when the
// drive sum was clipped to 32 bits. Gains and the integral bound are written
// on the cfg_ channel (index 0 kp, 1 ki, 2 kd, 3 limit); the user must write
// them only while idle, which the block itself does not enforce. cfg_ready is
// high whenever reset is released and unknown indexes are dropped. The work
// of a request is the restoring divider of the derivative term, 36 one-bit
// steps, plus 14 microcode steps around the single shared multiplier.
// s_tready is high only in the idle step, so one request is worked on at a time.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver still stalls when the next result is
// ready, the sequencer holds in place until m_tready is seen.
// aresetn is synchronous and active low: it restores the gain defaults,
// clears the integral and the previous error, and drops m_tvalid.
// Depends on pwic_pkg, pwic_sequencer and pwic_datapath.
`default_nettype none

module pid_with_integral_clamp (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] error_value, [31:16] time_step
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] drive_value
    output logic             m_tuser,   // [0] output_saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pwic_pkg::*;

    pwic_ctrl_t   ctrl;
    pwic_status_t status;
    logic         cnt_nz;

    assign status = '{in_valid: s_tvalid, out_busy: m_tvalid && !m_tready, cnt_nz: cnt_nz};
    assign s_tready  = aresetn && (ctrl.op == OP_LOAD);
    assign cfg_ready = aresetn;

    pwic_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    pwic_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .in_valid         (s_tvalid),
        .error_value      (s_tdata[15:0]),
        .time_step        (s_tdata[31:16]),
        .cfg_write        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .drive_value      (m_tdata),
        .output_saturated (m_tuser),
        .cnt_nz           (cnt_nz)
    );

endmodule

`default_nettype wire

[design/pwic_checker.sv]
// Port-level checks for the PID controller, bound to the top level.
// Depends on the assertion macros in pid_with_integral_clamp_defines.svh.
`default_nettype none

`include "pid_with_integral_clamp_defines.svh"

module pwic_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // A stalled result keeps its value.
    `PWIC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // One request is worked on at a time.
    `PWIC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !$rose(m_tvalid), "request overlap")

    // A saturated result is one of the two 32-bit extremes.
    `PWIC_ASSERT_NOW(a_sat_value, m_tvalid && m_tuser, m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000, "bad saturated value")

    // Configuration writes are never refused.
    `PWIC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind pid_with_integral_clamp pwic_checker u_pwic_checker (.*);

`default_nettype wire

[verif/pid_with_integral_clamp_checker.sv]
// Scoreboard for the PID controller: watches the config, request and result channels,
// keeps its own controller state and compares every result with its prediction.
// Depends on pwic_pkg for the register indexes and reset values.
module pid_with_integral_clamp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import pwic_pkg::*;

    typedef struct packed {
        logic [31:0] drive;
        logic        saturated;
    } drive_t;

    logic signed [15:0] kp = KP_RESET;
    logic signed [15:0] ki = '0;
    logic signed [15:0] kd = '0;
    logic [30:0]        limit = LIMIT_RESET;
    longint             integ = 0;
    logic signed [15:0] last_err = '0;

    drive_t drive_q[$];
    int     errors = 0;

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    // One controller step on the shadow state.
    function automatic drive_t pid_step(input logic signed [15:0] err,
                                        input logic [15:0] dt);
        longint acc;
        longint deriv;
        longint p_term;
        longint i_term;
        longint d_term;
        longint total;
        drive_t r;

        acc = integ + ((longint'(err) * longint'(dt)) >>> 4);
        if (acc > longint'(limit)) acc = longint'(limit);
        if (acc < -longint'(limit)) acc = -longint'(limit);
        integ = acc;

        // Signed division truncates toward zero; a zero step gives no derivative.
        if (dt != 0)
            deriv = ((longint'(err) - longint'(last_err)) * 1048576) / longint'(dt);
        else
            deriv = 0;
        last_err = err;

        p_term = (longint'(kp) * longint'(err)) >>> 4;
        i_term = (longint'(ki) * integ) >>> 16;
        d_term = (longint'(kd) * deriv) >>> 8;
        total = p_term + i_term + d_term;

        r.saturated = 1'b0;
        if (total > 64'sd2147483647) begin
            total = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        if (total < -64'sd2147483648) begin
            total = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.drive = total[31:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        drive_t want;
        if (!aresetn) begin
            kp = KP_RESET;
            ki = '0;
            kd = '0;
            limit = LIMIT_RESET;
            integ = 0;
            last_err = '0;
            drive_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KP_GAIN:        kp = cfg_data[15:0];
                    CFG_KI_GAIN:        ki = cfg_data[15:0];
                    CFG_KD_GAIN:        kd = cfg_data[15:0];
                    CFG_INTEGRAL_LIMIT: limit = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(pid_step(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: result drive %h saturated %b with no request pending",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = drive_q.pop_front();
                    if (m_tdata !== want.drive) begin
                        $display("%0t: drive_value expected %h, got %h",
                                 $time, want.drive, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.saturated) begin
                        $display("%0t: output_saturated expected %b, got %b",
                                 $time, want.saturated, m_tuser);
                        errors++;
                    end
                end
            end
        end
        // Published with a nonblocking update so readers at this edge see stable values.
        mismatches <= errors;
        outstanding <= drive_q.size();
    end

endmodule

[verif/pid_with_integral_clamp_test.sv]
// Top of the PID controller testbench: clock, reset, register writes, requests and
// result back-pressure. Depends on pwic_pkg, the block and pid_with_integral_clamp_checker.
module pid_with_integral_clamp_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pwic_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = CFG_KP_GAIN;
    logic [31:0] cfg_data = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_ready;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int stall_left = 0;
    bit steady = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    pid_with_integral_clamp DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pid_with_integral_clamp_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result back-pressure: mostly short stalls, now and then a long one that
    // outlasts the next computation.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) == 0) begin
            stall_left = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(input logic [15:0] err, input logic [15:0] dt);
        int gap;
        if (!steady && $urandom_range(0, 99) < 6) begin
            gap = $urandom_range(1, 60);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dt, err};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every request has produced its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Unused upper data bits carry noise, and a write to an unknown index must be dropped.
    task automatic configure(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [30:0] lim);
        logic [31:0] noise;
        noise = $urandom;
        put_reg(CFG_KP_GAIN, {noise[31:16], kp});
        put_reg(CFG_KI_GAIN, {noise[15:0], ki});
        put_reg(CFG_KD_GAIN, {~noise[31:16], kd});
        put_reg(CFG_INTEGRAL_LIMIT, {noise[0], lim});
        put_reg(8'($urandom_range(4, 255)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 512));
            4: return -16'($urandom_range(1, 512));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 31'd0;
            1: return 31'h7FFFFFFF;
            2: return 31'($urandom_range(1, 1 << 22));
            default: return 31'($urandom);
        endcase
    endfunction

    // A nonzero lean fixes the sign so the integral runs into its bound.
    function automatic logic [15:0] pick_error(input int lean);
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: v = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                        : -16'($urandom_range(0, 64));
            default: v = 16'($urandom);
        endcase
        if (lean > 0) v[15] = 1'b0;
        else if (lean < 0) v[15] = 1'b1;
        return v;
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int lean;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset gains: proportional term only.
        send(16'h0000, 16'h0001);
        send(16'h7FFF, 16'hFFFF);
        send(16'h8000, 16'hFFFF);
        send(16'h8000, 16'h0001);
        send(16'h7FFF, 16'h0000);
        send(16'h0000, 16'h0000);
        drain();

        // Largest positive gains and bound: integral growth and output clipping.
        configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h7FFFFFFF);
        send(16'h7FFF, 16'hFFFF);
        send(16'h7FFF, 16'hFFFF);
        send(16'h7FFF, 16'hFFFF);
        send(16'h8000, 16'h0001);
        send(16'h7FFF, 16'h0001);
        send(16'h0000, 16'h0000);
        send(16'hFFFF, 16'hFFFF);
        drain();

        // Most negative gains with a zero bound, which pins the integral at zero.
        configure(16'h8000, 16'h8000, 16'h8000, 31'd0);
        send(16'h7FFF, 16'hFFFF);
        send(16'h8000, 16'h0001);
        send(16'h7FFF, 16'h0000);
        send(16'h5555, 16'hAAAA);
        send(16'hAAAA, 16'h5555);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady = (phase == 2);
            if (phase == RANDOM_PHASES - 1)
                configure(16'h7FFF, 16'h8000, 16'h7FFF, 31'h7FFFFFFF);
            else
                configure(pick_gain(), pick_gain(), pick_gain(), pick_limit());
            lean = int'($urandom_range(0, 2)) - 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send(pick_error(lean), pick_step());
            drain();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
